// File: hdl/rtfm_pkg.sv
`timescale 1ns / 1ps

package rtfm_pkg;

    localparam int ROUTE_ENTRIES = 8;
    localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

    localparam int INDEX_FIELD_W = 3;
    localparam int ADDR_W        = 32;
    localparam int HOP_W         = 8;

    localparam logic [HOP_W-1:0] HOP_IFACE_BASE = 8'd100;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [HOP_W-1:0]  hop;
    } route_entry_t;

    typedef struct packed {
        logic                     matched;
        logic [INDEX_FIELD_W-1:0] match_index;
        logic                     to_interface;
        logic [HOP_W-1:0]         hop_number;
        logic                     use_default;
    } res_payload_t;

    typedef struct packed {
        logic             write_entry;
        logic             start_lookup;
        logic             issue_read;
        logic [IDX_W-1:0] rd_addr;
        logic             capture;
        logic             load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic cmp_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/rtfm_req_if.sv
`timescale 1ns / 1ps

interface rtfm_req_if;
    import rtfm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [INDEX_FIELD_W-1:0] entry_index;
    logic [ADDR_W-1:0]        entry_dest;
    logic [ADDR_W-1:0]        entry_mask;
    logic [HOP_W-1:0]         entry_hop;
    logic [ADDR_W-1:0]        lookup_addr;

    modport source (
        output valid, req_type, entry_index, entry_dest, entry_mask, entry_hop, lookup_addr,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, entry_dest, entry_mask, entry_hop, lookup_addr,
        output ready
    );

endinterface

// File: hdl/rtfm_res_if.sv
`timescale 1ns / 1ps

interface rtfm_res_if;
    import rtfm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     matched;
    logic [INDEX_FIELD_W-1:0] match_index;
    logic                     to_interface;
    logic [HOP_W-1:0]         hop_number;
    logic                     use_default;

    modport source (
        output valid, matched, match_index, to_interface, hop_number, use_default,
        input  ready
    );

    modport sink (
        input  valid, matched, match_index, to_interface, hop_number, use_default,
        output ready
    );

endinterface

// File: hdl/rtfm_controller.sv
`timescale 1ns / 1ps

module rtfm_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    rtfm_req_if.sink             request,
    input  rtfm_pkg::dp_status_t status,
    output rtfm_pkg::dp_cmd_t    cmd
);
    import rtfm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             issue;

    assign issue         = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(ROUTE_ENTRIES));
    assign request.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cmd               = '0;
        cmd.issue_read    = issue;
        cmd.rd_addr       = cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.req_type == REQ_LOOKUP)
                    begin
                        cmd.start_lookup = 1'b1;
                        cnt_next         = '0;
                        state_next       = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (status.hit || status.cmp_last)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hdl/rtfm_datapath.sv
`timescale 1ns / 1ps

module rtfm_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rtfm_pkg::dp_cmd_t                      cmd,
    output rtfm_pkg::dp_status_t                   status,
    input  logic [rtfm_pkg::INDEX_FIELD_W-1:0]     entry_index,
    input  logic [rtfm_pkg::ADDR_W-1:0]            entry_dest,
    input  logic [rtfm_pkg::ADDR_W-1:0]            entry_mask,
    input  logic [rtfm_pkg::HOP_W-1:0]             entry_hop,
    input  logic [rtfm_pkg::ADDR_W-1:0]            lookup_addr,
    rtfm_res_if.source                             result
);
    import rtfm_pkg::*;

    route_entry_t             route_mem [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     write_en;

    route_entry_t             rd_entry_reg;
    logic                     rd_valid_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_live_reg, cmp_live_next;
    logic [ADDR_W-1:0]        addr_reg;

    logic                     hold_found_reg;
    logic [IDX_W-1:0]         hold_idx_reg;
    logic [HOP_W-1:0]         hold_code_reg;

    logic                     res_valid_reg, res_valid_next;
    res_payload_t             res_reg, res_next;
    logic                     is_iface;

    assign write_en = cmd.write_entry && (int'(entry_index) < ROUTE_ENTRIES);

    always_comb
    begin
        valid_next = valid_reg;
        if (write_en)
        begin
            valid_next[IDX_W'(entry_index)] = 1'b1;
        end
    end

    assign cmp_live_next = cmd.issue_read;

    assign status.hit      = cmp_live_reg && rd_valid_reg
                             && ((addr_reg & rd_entry_reg.mask) == rd_entry_reg.dest);
    assign status.cmp_last = cmp_live_reg && (cmp_idx_reg == IDX_W'(ROUTE_ENTRIES - 1));
    assign status.out_free = !res_valid_reg || result.ready;

    assign is_iface = (hold_code_reg >= HOP_IFACE_BASE);

    always_comb
    begin
        res_next              = '0;
        res_next.matched      = hold_found_reg;
        res_next.use_default  = !hold_found_reg;
        if (hold_found_reg)
        begin
            res_next.match_index  = INDEX_FIELD_W'(hold_idx_reg);
            res_next.to_interface = is_iface;
            res_next.hop_number   = is_iface ? (hold_code_reg - HOP_IFACE_BASE) : hold_code_reg;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            route_mem[IDX_W'(entry_index)] <= '{dest: entry_dest, mask: entry_mask, hop: entry_hop};
        end
        if (cmd.issue_read)
        begin
            rd_entry_reg <= route_mem[cmd.rd_addr];
            rd_valid_reg <= valid_reg[cmd.rd_addr];
            cmp_idx_reg  <= cmd.rd_addr;
        end
        if (cmd.start_lookup)
        begin
            addr_reg <= lookup_addr;
        end
        if (cmd.capture)
        begin
            hold_found_reg <= status.hit;
            hold_idx_reg   <= cmp_idx_reg;
            hold_code_reg  <= rd_entry_reg.hop;
        end
        if (cmd.load_out)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cmp_live_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cmp_live_reg  <= cmp_live_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.matched      = res_reg.matched;
    assign result.match_index  = res_reg.match_index;
    assign result.to_interface = res_reg.to_interface;
    assign result.hop_number   = res_reg.hop_number;
    assign result.use_default  = res_reg.use_default;

endmodule

// File: hdl/route_table_first_match_lookup.sv
`timescale 1ns / 1ps

// Routing table with first-match lookup.
// request: one transaction either writes a table entry (req_type 0: entry_index,
//   entry_dest, entry_mask, entry_hop) or looks up lookup_addr (req_type 1).
// result: one transaction per lookup, none per write. Codes of 100 and above
//   are reported as an interface number (code minus 100), lower codes as a router.
// A write completes without leaving the idle state; writes to slots beyond the table are dropped.
// A lookup reads one entry from the table memory per cycle and compares it in the
//   next, stopping at the first valid match. A hit, or a miss once the last entry
//   is compared, is captured into the hold registers and then loaded into the result
//   register when it is free; request.ready rises in the same cycle as result.valid.
// The result register frees the scan from the receiver; if result.ready stays low,
//   a finished lookup waits and request.ready stays low until the register drains.
// Reset clears every entry valid bit, the scan state and the result valid flag;
//   no clearing pass runs, so the block takes requests right after reset.

module route_table_first_match_lookup (
    input  logic       clk,
    input  logic       rst_n,
    rtfm_req_if.sink   request,
    rtfm_res_if.source result
);
    import rtfm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rtfm_controller u_controller (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .status  (status),
        .cmd     (cmd)
    );

    rtfm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (request.entry_index),
        .entry_dest  (request.entry_dest),
        .entry_mask  (request.entry_mask),
        .entry_hop   (request.entry_hop),
        .lookup_addr (request.lookup_addr),
        .result      (result)
    );

    a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.req_type == REQ_LOOKUP))
        |=> !request.ready)
        else $error("request taken while a lookup is in progress");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.req_type == REQ_WRITE) && !result.valid)
        |=> !result.valid)
        else $error("write transaction produced a result");

    a_default_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.matched)
        |-> (result.use_default && !result.to_interface
             && (result.hop_number == '0) && (result.match_index == '0)))
        else $error("miss result carries non-default fields");

    a_match_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.matched) |-> !result.use_default)
        else $error("hit result flags the default route");

endmodule
